// ===== rtl/brb_pkg.sv =====
`default_nettype none

package brb_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int MAX_BURST_DEF  = 64;
    localparam int PUSH_LANES_DEF = 8;

    localparam int KIND_W  = 2;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 11;
    localparam int BYTE_W  = 8;
    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int BYTES_W = LANES * BYTE_W;

    // command queue between front and back, result buffer in the back
    localparam int CMDQ_DEPTH = 2;
    localparam int OBUF_DEPTH = 4;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] push_bytes;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              accepted;
        logic              last;
        logic [CAP_W-1:0]  free_bytes;
    } t_out_item;

    // classified operation; free_bytes is the value before a pop or peek,
    // the value after the operation otherwise
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic               accepted;
        logic [BYTES_W-1:0] push_bytes;
        logic [CAP_W-1:0]   free_bytes;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/brb_ram.sv =====
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/brb_cmd_queue.sv =====
`default_nettype none

module brb_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire brb_pkg::t_cmd i_wdata,
    output logic               o_full,
    input  wire logic          i_rd,
    output brb_pkg::t_cmd      o_rdata,
    output logic               o_empty
);

    localparam int QD = brb_pkg::CMDQ_DEPTH;
    localparam int QA = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC = $clog2(QD + 1);

    brb_pkg::t_cmd r_mem [QD];
    logic [QA-1:0] r_head, r_tail;
    logic [QC-1:0] r_count;
    logic          do_wr, do_rd;

    assign o_full  = (r_count == QC'(QD));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_head];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_tail <= (r_tail == QA'(QD - 1)) ? '0 : r_tail + QA'(1);
            end
            if (do_rd) begin
                r_head <= (r_head == QA'(QD - 1)) ? '0 : r_head + QA'(1);
            end
            r_count <= r_count + QC'(do_wr) - QC'(do_rd);
        end
        if (do_wr) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/brb_front.sv =====
`default_nettype none

module brb_front #(
    parameter int MAX_BURST  = brb_pkg::MAX_BURST_DEF,
    parameter int PUSH_LANES = brb_pkg::PUSH_LANES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic [brb_pkg::CAP_W-1:0] i_capacity,
    input  wire logic                      i_take,
    input  wire brb_pkg::t_in_item         i_item,
    output logic                           o_cmd_wr,
    output brb_pkg::t_cmd                  o_cmd
);

    localparam int CW = brb_pkg::CAP_W;

    // occupancy as seen after every classified operation
    logic [CW-1:0] r_stored, n_stored;
    logic [CW:0]   sum;
    logic          push_ok, rd_ok, ok;

    always_comb begin
        sum     = (CW + 1)'(r_stored) + (CW + 1)'(i_item.count);
        push_ok = (i_item.count <= brb_pkg::COUNT_W'(PUSH_LANES))
                  && (sum <= (CW + 1)'(i_capacity));
        rd_ok   = (CW'(i_item.count) <= r_stored)
                  && ((i_item.kind == brb_pkg::KIND_ERASE)
                      || (i_item.count <= brb_pkg::COUNT_W'(MAX_BURST)));
        ok      = (i_item.kind == brb_pkg::KIND_PUSH) ? push_ok : rd_ok;

        n_stored = r_stored;
        if (ok) begin
            case (i_item.kind)
                brb_pkg::KIND_PUSH:  n_stored = sum[CW-1:0];
                brb_pkg::KIND_POP,
                brb_pkg::KIND_ERASE: n_stored = r_stored - CW'(i_item.count);
                default:             n_stored = r_stored;
            endcase
        end

        o_cmd.kind       = i_item.kind;
        o_cmd.count      = i_item.count;
        o_cmd.accepted   = ok;
        o_cmd.push_bytes = i_item.push_bytes;
        o_cmd.free_bytes = (ok && i_item.kind == brb_pkg::KIND_POP)
                           ? i_capacity - r_stored
                           : i_capacity - n_stored;
        o_cmd_wr = i_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_stored <= '0;
        end else if (i_take) begin
            r_stored <= n_stored;
        end
    end

    a_stored_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= i_capacity)
        else $error("occupancy above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_stored == '0)
        else $error("capacity write left bytes stored");

endmodule

`default_nettype wire

// ===== rtl/brb_back.sv =====
`default_nettype none

module brb_back #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic [brb_pkg::CAP_W-1:0] i_capacity,
    input  wire brb_pkg::t_cmd             i_cmd,
    input  wire logic                      i_cmd_empty,
    output logic                           o_cmd_rd,
    output brb_pkg::t_out_item             o_result,
    output logic                           o_empty,
    input  wire logic                      i_pop
);

    localparam int CW   = brb_pkg::CAP_W;
    localparam int NW   = brb_pkg::COUNT_W;
    localparam int BW   = brb_pkg::BYTE_W;
    localparam int PW   = $clog2(DEPTH);
    localparam int XW   = (PW > CW) ? PW + 1 : CW + 1;
    localparam int OBD  = brb_pkg::OBUF_DEPTH;
    localparam int OBA  = $clog2(OBD);
    localparam int OBC  = $clog2(OBD + 1) + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_PUSH, ST_READ, ST_SINGLE} t_state;

    typedef struct packed {
        logic          from_ram;
        logic          accepted;
        logic          last;
        logic [CW-1:0] free_bytes;
    } t_stage;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p,
                                               input logic [CW-1:0] cap);
        logic [XW-1:0] nxt;
        nxt = XW'(p) + XW'(1);
        return (nxt >= XW'(cap)) ? '0 : nxt[PW-1:0];
    endfunction

    t_state             r_state, n_state;
    brb_pkg::t_cmd      r_cmd, n_cmd;
    logic [NW-1:0]      r_idx, n_idx;
    logic [PW-1:0]      r_wptr, n_wptr, r_rptr, n_rptr, r_ptr, n_ptr;
    logic [CW-1:0]      r_free, n_free, free_step;
    logic               r_st_valid, n_st_valid;
    t_stage             r_st, n_st;
    brb_pkg::t_out_item r_obuf [OBD];
    logic [OBA-1:0]     r_ohead, r_otail;
    logic [OBC-1:0]     r_ocount;
    logic               room, ob_pop, is_last;
    logic [XW-1:0]      erase_sum;
    logic               ram_we;
    logic [BW-1:0]      ram_wdata, ram_q;

    brb_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_storage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_q)
    );

    assign room      = (r_ocount + OBC'(r_st_valid)) < OBC'(OBD);
    assign ob_pop    = i_pop && (r_ocount != '0);
    assign o_empty   = (r_ocount == '0);
    assign o_result  = r_obuf[r_ohead];
    assign ram_wdata = r_cmd.push_bytes[{r_idx[brb_pkg::LANE_W-1:0], 3'b000} +: BW];
    assign is_last   = (r_idx == r_cmd.count - NW'(1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_ptr      = r_ptr;
        n_free     = r_free;
        n_st_valid = 1'b0;
        n_st       = r_st;
        o_cmd_rd   = 1'b0;
        ram_we     = 1'b0;
        free_step  = (r_cmd.kind == brb_pkg::KIND_POP) ? r_free + CW'(1) : r_free;
        erase_sum  = XW'(r_rptr) + XW'(i_cmd.count);
        if (erase_sum >= XW'(i_capacity)) begin
            erase_sum = erase_sum - XW'(i_capacity);
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_rd = 1'b1;
                    n_cmd    = i_cmd;
                    n_idx    = '0;
                    n_free   = i_cmd.free_bytes;
                    n_ptr    = r_rptr;
                    n_state  = ST_SINGLE;
                    if (i_cmd.accepted && i_cmd.count != '0) begin
                        case (i_cmd.kind)
                            brb_pkg::KIND_PUSH: n_state = ST_PUSH;
                            brb_pkg::KIND_POP,
                            brb_pkg::KIND_PEEK: n_state = ST_READ;
                            default:            n_rptr  = erase_sum[PW-1:0];
                        endcase
                    end
                end
            end
            ST_PUSH: begin
                ram_we = 1'b1;
                n_wptr = wrap_inc(r_wptr, i_capacity);
                n_idx  = r_idx + NW'(1);
                if (is_last) begin
                    n_state = ST_SINGLE;
                end
            end
            ST_SINGLE: begin
                if (room) begin
                    n_st_valid      = 1'b1;
                    n_st.from_ram   = 1'b0;
                    n_st.accepted   = r_cmd.accepted;
                    n_st.last       = 1'b1;
                    n_st.free_bytes = r_free;
                    n_state         = ST_IDLE;
                end
            end
            ST_READ: begin
                if (room) begin
                    n_st_valid      = 1'b1;
                    n_st.from_ram   = 1'b1;
                    n_st.accepted   = 1'b1;
                    n_st.last       = is_last;
                    n_st.free_bytes = free_step;
                    n_free          = free_step;
                    n_ptr           = wrap_inc(r_ptr, i_capacity);
                    if (r_cmd.kind == brb_pkg::KIND_POP) begin
                        n_rptr = wrap_inc(r_ptr, i_capacity);
                    end
                    n_idx = r_idx + NW'(1);
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_clear) begin
            n_wptr = '0;
            n_rptr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_st_valid <= 1'b0;
            r_ohead    <= '0;
            r_otail    <= '0;
            r_ocount   <= '0;
        end else begin
            r_state    <= n_state;
            r_wptr     <= n_wptr;
            r_rptr     <= n_rptr;
            r_st_valid <= n_st_valid;
            if (r_st_valid) begin
                r_otail <= r_otail + OBA'(1);
            end
            if (ob_pop) begin
                r_ohead <= r_ohead + OBA'(1);
            end
            r_ocount <= r_ocount + OBC'(r_st_valid) - OBC'(ob_pop);
        end
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_ptr  <= n_ptr;
        r_free <= n_free;
        r_st   <= n_st;
        if (r_st_valid) begin
            r_obuf[r_otail].data_byte  <= r_st.from_ram ? ram_q : '0;
            r_obuf[r_otail].accepted   <= r_st.accepted;
            r_obuf[r_otail].last       <= r_st.last;
            r_obuf[r_otail].free_bytes <= r_st.free_bytes;
        end
    end

    a_stage_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st_valid |-> r_ocount < OBC'(OBD))
        else $error("result buffer overrun");

    a_push_state_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (r_cmd.kind == brb_pkg::KIND_PUSH && r_cmd.accepted))
        else $error("push sequence without accepted push");

    a_wptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_wptr) < XW'(i_capacity))
        else $error("write pointer outside ring");

endmodule

`default_nettype wire

// ===== rtl/byte_ring_buffer.sv =====
// path: a word is stored in the command queue before the back loads it; its result word then
//   passes the stage register and the result buffer on its way to the result ports, a push
//   writing all its bytes to storage first
// sequencing: the back finishes one word before it loads the next; a push writes one byte
//   to storage at a time; pop and peek read one at a time, stalling on a full result buffer
// reset: synchronous active low; clears pointers, occupancy and both queues,
//   capacity goes to the smaller of DEPTH and 1024; byte storage is not cleared
`default_nettype none

module byte_ring_buffer #(
    parameter int DEPTH      = brb_pkg::DEPTH_DEF,
    parameter int MAX_BURST  = brb_pkg::MAX_BURST_DEF,
    parameter int PUSH_LANES = brb_pkg::PUSH_LANES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input word queue side
    input  wire logic                      push,
    output logic                           full,
    input  wire brb_pkg::t_in_item         i_item,
    // result word queue side
    output logic                           empty,
    input  wire logic                      pop,
    output brb_pkg::t_out_item             o_result,
    // capacity register
    input  wire logic                      i_cfg_we,
    input  wire logic [brb_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int CW = brb_pkg::CAP_W;
    // highest capacity the register can hold, and its value after reset
    localparam logic [CW-1:0] CAP_LIMIT = CW'((DEPTH > 2047) ? 2047 : DEPTH);
    localparam logic [CW-1:0] CAP_RESET = CW'((DEPTH > 1024) ? 1024 : DEPTH);

    logic [CW-1:0] r_capacity;
    logic          take;
    logic          cmd_wr, cmd_full, cmd_rd, cmd_empty;
    brb_pkg::t_cmd cmd_in, cmd_out;

    // capacity write: zero counts as one, values above the storage saturate;
    // the same write empties the ring in front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_capacity <= CW'(1);
            end else if (i_cfg_data > CAP_LIMIT) begin
                r_capacity <= CAP_LIMIT;
            end else begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // a word enters whenever the command queue has a slot
    assign full = cmd_full;
    assign take = push && !cmd_full;

    // front: checks space or data and keeps the running occupancy
    brb_front #(
        .MAX_BURST  (MAX_BURST),
        .PUSH_LANES (PUSH_LANES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_we),
        .i_capacity (r_capacity),
        .i_take     (take),
        .i_item     (i_item),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in)
    );

    // short queue of classified operations decouples the two sides
    brb_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_rd),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    // back: owns the pointers and storage, walks bytes and buffers results
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_capacity  (r_capacity),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_rd    (cmd_rd),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire
